// ----- rtl/cau_pkg.sv -----
// Shared definitions for the complex arithmetic unit: opcodes, status codes,
// default widths and the control word that steps the divider pipeline.
// No dependencies.
`default_nettype none

package cau_pkg;

    // Default operand format: signed Q16.16
    localparam int CAU_DATA_WIDTH = 32;
    localparam int CAU_FRAC_BITS  = 16;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_DZ  = 2'd2
    } status_t;

    // Pipeline step control handed to the divider
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cau_div_pipe.sv -----
// Pipelined restoring divider: two quotients over one shared divisor,
// one quotient bit per register stage, with a tag word carried alongside.
// Depends on cau_pkg.
`default_nettype none

module cau_div_pipe
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = CAU_FRAC_BITS,
    parameter int TAG_WIDTH  = 1
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pipe_ctl_t                 ctl,
    input  logic [2*DATA_WIDTH-1:0]   num_re,
    input  logic [2*DATA_WIDTH-1:0]   num_im,
    input  logic [2*DATA_WIDTH-1:0]   den,
    input  logic [TAG_WIDTH-1:0]      tag_in,
    output logic                      valid_out,
    output logic [DATA_WIDTH-1:0]     q_re,
    output logic [DATA_WIDTH-1:0]     q_im,
    output logic                      big_re,
    output logic                      big_im,
    output logic [TAG_WIDTH-1:0]      tag_out
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int NW = PW + FRAC_BITS;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The dividend bits leave the top of w while quotient bits enter below.
    function automatic logic [PW+DW-1:0] div_step(
        input logic [PW-1:0] rem,
        input logic [DW-1:0] w,
        input logic [PW-1:0] d
    );
        logic [PW:0] t;
        logic        q;
        t = {rem, w[DW-1]};
        q = (t >= {1'b0, d});
        if (q)
        begin
            t = t - {1'b0, d};
        end
        return {t[PW-1:0], w[DW-2:0], q};
    endfunction

    logic                 v_reg   [0:DW];
    logic [PW-1:0]        rre_reg [0:DW];
    logic [PW-1:0]        rim_reg [0:DW];
    logic [DW-1:0]        wre_reg [0:DW];
    logic [DW-1:0]        wim_reg [0:DW];
    logic                 bre_reg [0:DW];
    logic                 bim_reg [0:DW];
    logic [PW-1:0]        den_reg [0:DW];
    logic [TAG_WIDTH-1:0] tag_reg [0:DW];

    logic [NW-1:0] dvd_re;
    logic [NW-1:0] dvd_im;
    logic [NW-1:0] hi_re;
    logic [NW-1:0] hi_im;

    // Entry: scale the numerator, split off the starting remainder and flag
    // quotients that cannot fit in DW bits
    always_comb
    begin
        dvd_re = NW'(num_re) << FRAC_BITS;
        dvd_im = NW'(num_im) << FRAC_BITS;
        hi_re  = dvd_re >> DW;
        hi_im  = dvd_im >> DW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (ctl.en)
        begin
            v_reg[0] <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rre_reg[0] <= hi_re[PW-1:0];
            rim_reg[0] <= hi_im[PW-1:0];
            wre_reg[0] <= dvd_re[DW-1:0];
            wim_reg[0] <= dvd_im[DW-1:0];
            bre_reg[0] <= (hi_re >= NW'(den));
            bim_reg[0] <= (hi_im >= NW'(den));
            den_reg[0] <= den;
            tag_reg[0] <= tag_in;
        end
    end

    // Quotient stages, one bit each
    for (genvar k = 1; k <= DW; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ctl.en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                {rre_reg[k], wre_reg[k]} <= div_step(rre_reg[k-1], wre_reg[k-1],
                                                     den_reg[k-1]);
                {rim_reg[k], wim_reg[k]} <= div_step(rim_reg[k-1], wim_reg[k-1],
                                                     den_reg[k-1]);
                bre_reg[k] <= bre_reg[k-1];
                bim_reg[k] <= bim_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign valid_out = v_reg[DW];
    assign q_re      = wre_reg[DW];
    assign q_im      = wim_reg[DW];
    assign big_re    = bre_reg[DW];
    assign big_im    = bim_reg[DW];
    assign tag_out   = tag_reg[DW];

endmodule

`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit top level: add, subtract, multiply, divide and
// compare on signed fixed-point complex words. Depends on cau_pkg, cau_div_pipe.
//
// Usage:
//   Input channel in_valid/in_ready carries opcode, a_re, a_im, b_re, b_im.
//   Output channel out_valid/out_ready carries res_re, res_im, equal, status.
//   A word is taken on a clock edge where valid and ready are both high.
//   Throughput is one word per cycle while the skid register is empty.
//   Every opcode runs through the same pipeline: operand register,
//   multiplier stage, product-sum stage, sign/magnitude stage, divider
//   load stage, one stage per quotient bit (DATA_WIDTH of them, the long
//   pole), then the output register.
//   The output register is backed by a one-word skid register: while the
//   receiver stalls, one more result is parked there and in_ready stays
//   high until it fills; then the whole pipeline holds, losing nothing.
//   Reset (rst_n low, asynchronous) clears all valid bits; the block is
//   ready as soon as reset is released.
//   Status: 0 ok, 1 a part saturated, 2 divide by zero (result zero).
`default_nettype none

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = CAU_FRAC_BITS
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   opcode,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic                         equal,
    output logic [1:0]                   status
);

    localparam int DW    = DATA_WIDTH;
    localparam int PW    = 2 * DATA_WIDTH;
    localparam int SW    = PW + 1;
    localparam int TAG_W = PW + 7;

    localparam logic [DW-1:0] HALF = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] SMAX = ~HALF;
    localparam logic [DW-1:0] SMIN = HALF;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          eq;
        status_t       st;
    } res_word_t;

    // Saturate a sign/magnitude value; returns {overflow, bits}
    function automatic logic [DW:0] sat_mag(
        input logic          neg,
        input logic          big,
        input logic [DW-1:0] mag
    );
        logic [DW:0] r;
        if (big)
        begin
            r = {1'b1, (neg ? SMIN : SMAX)};
        end
        else if (neg)
        begin
            if (mag > HALF)
            begin
                r = {1'b1, SMIN};
            end
            else
            begin
                r = {1'b0, -mag};
            end
        end
        else if (mag[DW-1])
        begin
            r = {1'b1, SMAX};
        end
        else
        begin
            r = {1'b0, mag};
        end
        return r;
    endfunction

    // Saturate a DW+1 bit signed sum; returns {overflow, bits}
    function automatic logic [DW:0] sat_sum(input logic [DW:0] s);
        logic [DW:0] r;
        if (s[DW] != s[DW-1])
        begin
            r = {1'b1, (s[DW] ? SMIN : SMAX)};
        end
        else
        begin
            r = {1'b0, s[DW-1:0]};
        end
        return r;
    endfunction

    logic adv;
    logic skid_v_reg;
    logic out_v_reg;

    // Pipeline advances unless the skid register is occupied
    assign adv      = !skid_v_reg;
    assign in_ready = adv;

    // ---------------- Stage A: operand register
    logic                 a_v_reg;
    opcode_t              a_op_reg;
    logic signed [DW-1:0] a_ar_reg;
    logic signed [DW-1:0] a_ai_reg;
    logic signed [DW-1:0] a_br_reg;
    logic signed [DW-1:0] a_bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg <= opcode_t'(opcode);
            a_ar_reg <= a_re;
            a_ai_reg <= a_im;
            a_br_reg <= b_re;
            a_bi_reg <= b_im;
        end
    end

    // ---------------- Stage B: products, add/sub sums, equality
    logic                 b_v_reg;
    opcode_t              b_op_reg;
    logic signed [PW-1:0] b_rr_reg;
    logic signed [PW-1:0] b_ii_reg;
    logic signed [PW-1:0] b_ir_reg;
    logic signed [PW-1:0] b_ri_reg;
    logic signed [PW-1:0] b_bbr_reg;
    logic signed [PW-1:0] b_bbi_reg;
    logic [DW:0]          b_sre_reg;
    logic [DW:0]          b_sim_reg;
    logic                 b_eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_op_reg  <= a_op_reg;
            b_rr_reg  <= a_ar_reg * a_br_reg;
            b_ii_reg  <= a_ai_reg * a_bi_reg;
            b_ir_reg  <= a_ai_reg * a_br_reg;
            b_ri_reg  <= a_ar_reg * a_bi_reg;
            b_bbr_reg <= a_br_reg * a_br_reg;
            b_bbi_reg <= a_bi_reg * a_bi_reg;
            if (a_op_reg == OP_SUB)
            begin
                b_sre_reg <= {a_ar_reg[DW-1], a_ar_reg} - {a_br_reg[DW-1], a_br_reg};
                b_sim_reg <= {a_ai_reg[DW-1], a_ai_reg} - {a_bi_reg[DW-1], a_bi_reg};
            end
            else
            begin
                b_sre_reg <= {a_ar_reg[DW-1], a_ar_reg} + {a_br_reg[DW-1], a_br_reg};
                b_sim_reg <= {a_ai_reg[DW-1], a_ai_reg} + {a_bi_reg[DW-1], a_bi_reg};
            end
            b_eq_reg <= (a_ar_reg == a_br_reg) && (a_ai_reg == a_bi_reg);
        end
    end

    // ---------------- Stage C: product sums, divisor, add/sub saturation
    logic                 c_v_reg;
    opcode_t              c_op_reg;
    logic signed [SW-1:0] c_vre_reg;
    logic signed [SW-1:0] c_vim_reg;
    logic [PW-1:0]        c_den_reg;
    logic [DW-1:0]        c_nre_reg;
    logic [DW-1:0]        c_nim_reg;
    logic                 c_novf_reg;
    logic                 c_eq_reg;

    logic [DW:0] sat_re;
    logic [DW:0] sat_im;

    assign sat_re = sat_sum(b_sre_reg);
    assign sat_im = sat_sum(b_sim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_op_reg <= b_op_reg;
            if (b_op_reg == OP_MUL)
            begin
                c_vre_reg <= SW'(b_rr_reg) - SW'(b_ii_reg);
                c_vim_reg <= SW'(b_ir_reg) + SW'(b_ri_reg);
            end
            else
            begin
                // Numerator of a / b: a times conjugate of b
                c_vre_reg <= SW'(b_rr_reg) + SW'(b_ii_reg);
                c_vim_reg <= SW'(b_ir_reg) - SW'(b_ri_reg);
            end
            c_den_reg  <= $unsigned(b_bbr_reg) + $unsigned(b_bbi_reg);
            c_nre_reg  <= sat_re[DW-1:0];
            c_nim_reg  <= sat_im[DW-1:0];
            c_novf_reg <= sat_re[DW] | sat_im[DW];
            c_eq_reg   <= b_eq_reg;
        end
    end

    // ---------------- Stage D: sign and magnitude
    logic          d_v_reg;
    opcode_t       d_op_reg;
    logic          d_neg_re_reg;
    logic          d_neg_im_reg;
    logic [PW-1:0] d_mag_re_reg;
    logic [PW-1:0] d_mag_im_reg;
    logic [PW-1:0] d_den_reg;
    logic          d_dz_reg;
    logic [DW-1:0] d_nre_reg;
    logic [DW-1:0] d_nim_reg;
    logic          d_novf_reg;
    logic          d_eq_reg;

    logic [SW-1:0] abs_re;
    logic [SW-1:0] abs_im;

    always_comb
    begin
        abs_re = c_vre_reg[SW-1] ? (~c_vre_reg + 1'b1) : c_vre_reg;
        abs_im = c_vim_reg[SW-1] ? (~c_vim_reg + 1'b1) : c_vim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_op_reg     <= c_op_reg;
            d_neg_re_reg <= c_vre_reg[SW-1];
            d_neg_im_reg <= c_vim_reg[SW-1];
            d_mag_re_reg <= abs_re[PW-1:0];
            d_mag_im_reg <= abs_im[PW-1:0];
            d_den_reg    <= c_den_reg;
            d_dz_reg     <= (c_den_reg == '0);
            d_nre_reg    <= c_nre_reg;
            d_nim_reg    <= c_nim_reg;
            d_novf_reg   <= c_novf_reg;
            d_eq_reg     <= c_eq_reg;
        end
    end

    // ---------------- Non-divide results, carried as tag through the divider
    logic [PW-1:0]    sh_re;
    logic [PW-1:0]    sh_im;
    logic [DW:0]      mul_re;
    logic [DW:0]      mul_im;
    logic [DW-1:0]    nd_re;
    logic [DW-1:0]    nd_im;
    status_t          nd_st;
    logic [TAG_W-1:0] tag_in;

    always_comb
    begin
        // Truncate product magnitude toward zero, then saturate
        sh_re  = d_mag_re_reg >> FRAC_BITS;
        sh_im  = d_mag_im_reg >> FRAC_BITS;
        mul_re = sat_mag(d_neg_re_reg, |sh_re[PW-1:DW], sh_re[DW-1:0]);
        mul_im = sat_mag(d_neg_im_reg, |sh_im[PW-1:DW], sh_im[DW-1:0]);

        case (d_op_reg) inside
            OP_ADD, OP_SUB:
            begin
                nd_re = d_nre_reg;
                nd_im = d_nim_reg;
                nd_st = d_novf_reg ? ST_OVF : ST_OK;
            end
            OP_MUL:
            begin
                nd_re = mul_re[DW-1:0];
                nd_im = mul_im[DW-1:0];
                nd_st = (mul_re[DW] | mul_im[DW]) ? ST_OVF : ST_OK;
            end
            default:
            begin
                nd_re = '0;
                nd_im = '0;
                nd_st = ST_OK;
            end
        endcase

        tag_in = {(d_op_reg == OP_DIV), d_neg_re_reg, d_neg_im_reg, d_dz_reg,
                  nd_re, nd_im, nd_st, d_eq_reg};
    end

    // ---------------- Divider pipeline
    pipe_ctl_t        div_ctl;
    logic             fin_v;
    logic [DW-1:0]    q_re;
    logic [DW-1:0]    q_im;
    logic             big_re;
    logic             big_im;
    logic [TAG_W-1:0] tag_out;

    assign div_ctl.en    = adv;
    assign div_ctl.valid = d_v_reg;

    cau_div_pipe #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS),
        .TAG_WIDTH  (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .num_re    (d_mag_re_reg),
        .num_im    (d_mag_im_reg),
        .den       (d_den_reg),
        .tag_in    (tag_in),
        .valid_out (fin_v),
        .q_re      (q_re),
        .q_im      (q_im),
        .big_re    (big_re),
        .big_im    (big_im),
        .tag_out   (tag_out)
    );

    // ---------------- Final result select
    logic          t_div;
    logic          t_neg_re;
    logic          t_neg_im;
    logic          t_dz;
    logic [DW-1:0] t_re;
    logic [DW-1:0] t_im;
    logic [1:0]    t_st;
    logic          t_eq;
    logic [DW:0]   div_re;
    logic [DW:0]   div_im;
    res_word_t     fin_word;

    always_comb
    begin
        {t_div, t_neg_re, t_neg_im, t_dz, t_re, t_im, t_st, t_eq} = tag_out;
        div_re = sat_mag(t_neg_re, big_re, q_re);
        div_im = sat_mag(t_neg_im, big_im, q_im);
        fin_word.eq = t_eq;
        if (!t_div)
        begin
            fin_word.re = t_re;
            fin_word.im = t_im;
            fin_word.st = status_t'(t_st);
        end
        else if (t_dz)
        begin
            fin_word.re = '0;
            fin_word.im = '0;
            fin_word.st = ST_DZ;
        end
        else
        begin
            fin_word.re = div_re[DW-1:0];
            fin_word.im = div_im[DW-1:0];
            fin_word.st = (div_re[DW] | div_im[DW]) ? ST_OVF : ST_OK;
        end
    end

    // ---------------- Output register with skid word
    res_word_t out_reg;
    res_word_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_ready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (fin_v)
        begin
            if (out_v_reg && !out_ready)
            begin
                skid_v_reg <= 1'b1;
            end
            else
            begin
                out_v_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (fin_v)
        begin
            if (out_v_reg && !out_ready)
            begin
                skid_reg <= fin_word;
            end
            else
            begin
                out_reg <= fin_word;
            end
        end
    end

    assign out_valid = out_v_reg;
    assign res_re    = out_reg.re;
    assign res_im    = out_reg.im;
    assign equal     = out_reg.eq;
    assign status    = out_reg.st;

`ifndef SYNTH
    // Skid word is only ever held behind a valid output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid word held without output word");

    // Skid fills only after a stalled output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !out_ready))
        else $error("skid filled without a stall");

    // Divide by zero always returns zero parts
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_reg.st == ST_DZ) |-> (out_reg.re == '0 && out_reg.im == '0))
        else $error("divide by zero with nonzero result");

    // No undefined status code leaves the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (status == ST_OK || status == ST_OVF || status == ST_DZ))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire
